// ----- hw/rtl/kvt_pkg.sv -----
`default_nettype none

package kvt_pkg;

   typedef enum logic [1:0] {
      FUNC_DEFINE = 2'd0,
      FUNC_QUERY  = 2'd1,
      FUNC_ERASE  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_SHIFT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic latch_hit;
      logic write_hit;
      logic append;
      logic set_full;
      logic shift_start;
      logic shift_step;
      logic count_dec;
      logic reply;
   } ctl_cmd_type;

   typedef struct packed {
      func_type func;
      logic     hit;
      logic     hit_latched;
      logic     walk_done;
      logic     table_full;
      logic     rsp_free;
   } ctl_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/kvt_req_if.sv -----
`default_nettype none

interface kvt_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  func;
   logic signed [31:0] key;
   logic signed [31:0] value_in;

   modport source (output valid, output func, output key, output value_in, input ready);
   modport sink   (input valid, input func, input key, input value_in, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/kvt_rsp_if.sv -----
`default_nettype none

interface kvt_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic signed [31:0] value_out;
   logic               table_full;

   modport source (output valid, output found, output value_out, output table_full, input ready);
   modport sink   (input valid, input found, input value_out, input table_full, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/kvt_datapath.sv -----
`default_nettype none

module kvt_datapath
   import kvt_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_cmd_type        cmd,
   output      ctl_status_type     status,
   input  wire logic        [1:0]  item_func,
   input  wire logic signed [31:0] item_key,
   input  wire logic signed [31:0] item_value,
   input  wire logic               out_ready,
   output      logic               out_valid,
   output      logic               out_found,
   output      logic signed [31:0] out_value,
   output      logic               out_full
);

   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;

   logic [ENTRY_BITS-1:0] entry_mem [CAPACITY];
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;

   func_type              func_ff,      func_in;
   logic [KEY_BITS-1:0]   key_ff,       key_in;
   logic [VALUE_BITS-1:0] val_ff,       val_in;
   logic [CNT_BITS-1:0]   count_ff,     count_in;
   logic [CNT_BITS-1:0]   ptr_ff,       ptr_in;
   logic                  pend_ff,      pend_in;
   logic [CNT_BITS-1:0]   pend_idx_ff,  pend_idx_in;
   logic                  hit_ff,       hit_in;
   logic [CNT_BITS-1:0]   slot_ff,      slot_in;
   logic [VALUE_BITS-1:0] hit_val_ff,   hit_val_in;
   logic                  full_ff,      full_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff,     found_in;
   logic signed [31:0]    value_ff,     value_in;
   logic                  rsp_full_ff,  rsp_full_in;

   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic                  ptr_lt;
   logic                  step;

   assign rd_key = rd_data_ff[ENTRY_BITS-1:VALUE_BITS];
   assign rd_val = rd_data_ff[VALUE_BITS-1:0];
   assign ptr_lt = ptr_ff < count_ff;
   assign step   = cmd.scan_step || cmd.shift_step;
   assign rd_en  = step && ptr_lt;
   assign rd_addr = ptr_ff[IDX_BITS-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_ff[IDX_BITS-1:0];
      wr_data = {key_ff, val_ff};
      if (cmd.write_hit) begin
         wr_en = 1'b1;
      end else if (cmd.append) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_BITS-1:0];
      end else if (cmd.shift_step && pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = IDX_BITS'(pend_idx_ff - CNT_BITS'(1));
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   always_comb begin
      func_in      = func_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      hit_val_in   = hit_val_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      value_in     = value_ff;
      rsp_full_in  = rsp_full_ff;

      if (cmd.load) begin
         func_in = func_type'(item_func);
         key_in  = KEY_BITS'(item_key);
         val_in  = VALUE_BITS'(item_value);
         ptr_in  = '0;
         pend_in = 1'b0;
         hit_in  = 1'b0;
         full_in = 1'b0;
      end
      if (step) begin
         pend_in     = ptr_lt;
         pend_idx_in = ptr_ff;
         if (ptr_lt) begin
            ptr_in = ptr_ff + CNT_BITS'(1);
         end
      end
      if (cmd.latch_hit) begin
         hit_in     = 1'b1;
         slot_in    = pend_idx_ff;
         hit_val_in = rd_val;
      end
      if (cmd.shift_start) begin
         ptr_in  = slot_ff + CNT_BITS'(1);
         pend_in = 1'b0;
      end
      if (cmd.append) begin
         count_in = count_ff + CNT_BITS'(1);
      end
      if (cmd.count_dec) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      if (cmd.set_full) begin
         full_in = 1'b1;
      end

      if (cmd.reply) begin
         rsp_valid_in = 1'b1;
         found_in     = hit_ff;
         rsp_full_in  = full_ff;
         if (func_ff == FUNC_QUERY) begin
            value_in = hit_ff ? 32'($signed(hit_val_ff)) : '1;
         end else begin
            value_in = '0;
         end
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      ptr_ff      <= ptr_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      hit_val_ff  <= hit_val_in;
      found_ff    <= found_in;
      value_ff    <= value_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign status.func        = func_ff;
   assign status.hit         = pend_ff && (rd_key == key_ff);
   assign status.hit_latched = hit_ff;
   assign status.walk_done   = !pend_ff && (ptr_ff == count_ff);
   assign status.table_full  = count_ff == CNT_BITS'(CAPACITY);
   assign status.rsp_free    = !rsp_valid_ff || out_ready;

   assign out_valid = rsp_valid_ff;
   assign out_found = found_ff;
   assign out_value = value_ff;
   assign out_full  = rsp_full_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/kvt_controller.sv -----
`default_nettype none

module kvt_controller
   import kvt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_ready,
   input  wire ctl_status_type status,
   output      ctl_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               cmd.latch_hit = 1'b1;
               state_in      = ST_UPDATE;
            end else if (status.walk_done) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_UPDATE: begin
            state_in = ST_REPLY;
            case (status.func)
               FUNC_DEFINE: begin
                  if (status.hit_latched) begin
                     cmd.write_hit = 1'b1;
                  end else if (status.table_full) begin
                     cmd.set_full = 1'b1;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               FUNC_ERASE: begin
                  if (status.hit_latched) begin
                     cmd.shift_start = 1'b1;
                     state_in        = ST_SHIFT;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SHIFT: begin
            if (status.walk_done) begin
               cmd.count_dec = 1'b1;
               state_in      = ST_REPLY;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         ST_REPLY: begin
            if (status.rsp_free) begin
               cmd.reply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/key_value_table.sv -----
`default_nettype none

// Channel   Dir  Word                          Accepted when
// req_chan  in   func, key, value_in           req_chan.valid && req_chan.ready
// rsp_chan  out  found, value_out, table_full  rsp_chan.valid && rsp_chan.ready
//
// Each word walks the stored entries through the single read port of the entry
// memory, one entry per cycle; no new word is accepted until it has loaded its
// reply. An erase then moves every later entry down one place, one per cycle.
// Reset clears the entry count and the control state; the memory is not cleared.
// A new word is taken while the previous reply waits; a stalled reply holds
// the next word at its final step.

module key_value_table
   import kvt_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input wire logic clock,
   input wire logic reset,
   kvt_req_if.sink  req_chan,
   kvt_rsp_if.source rsp_chan
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   kvt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kvt_datapath #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .item_func  (req_chan.func),
      .item_key   (req_chan.key),
      .item_value (req_chan.value_in),
      .out_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_found  (rsp_chan.found),
      .out_value  (rsp_chan.value_out),
      .out_full   (rsp_chan.table_full)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while a word is in progress");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.found && rsp_chan.table_full))
      else $error("full flag raised for a key that was present");

   a_reply_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.reply |-> status.rsp_free)
      else $error("reply loaded over a pending word");

   a_append_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !status.table_full)
      else $error("append into a full table");

endmodule

`default_nettype wire
